### rtl/coordinate_compression_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks with synchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_COMPRESSION_TABLE_ASSERT_SVH
`define COORDINATE_COMPRESSION_TABLE_ASSERT_SVH

// same-cycle implication
`define CCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CCT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Beat types and operation and status codes of the compression table.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_BUILD = 3'd1;
  localparam logic [2:0] OP_LOWER = 3'd2;
  localparam logic [2:0] OP_UPPER = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [9:0]         index;
  } in_t;

  typedef struct packed {
    logic [10:0]        rank;
    logic signed [31:0] entry_value;
    logic [10:0]        entry_count;
    logic [1:0]         status;
  } out_t;

endpackage

### rtl/cct_out_stage.sv
// ----------------------------------------------------------------------------
// cct_out_stage
// Output register: holds a finished result beat until it is taken.
// ----------------------------------------------------------------------------
module cct_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  cct_pkg::out_t res,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output cct_pkg::out_t out_data
);
  import cct_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

### rtl/coordinate_compression_table.sv
// ----------------------------------------------------------------------------
// coordinate_compression_table
// Collects signed values, sorts and dedups them in place, answers rank
// queries by binary search and index reads over a single synchronous memory.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  input   | in_valid, in_ready, in_data    | opcode, value, index in
//  output  | out_valid, out_ready, out_data | rank, entry, count, status out
//
//  Add, unused codes and rejected queries go straight to done; a read
//  adds one memory read. Rank query: binary search, one memory read per step.
//  Build: insertion sort, one memory write per shifted entry and per key,
//  then a dedup pass over all entries; the memory port sets the pace.
//  No clearing pass after reset. A stalled output holds only the result
//  stage; the next beat is taken and waits in its final state.
// ----------------------------------------------------------------------------
`include "coordinate_compression_table_assert.svh"

module coordinate_compression_table #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cct_pkg::out_t out_data
);
  import cct_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SORT_KEY = 10'b0000000010,
    S_SORT_CMP = 10'b0000000100,
    S_SORT_INS = 10'b0000001000,
    S_DD_RD    = 10'b0000010000,
    S_DD_V0    = 10'b0000100000,
    S_DD_CMP   = 10'b0001000000,
    S_SRCH     = 10'b0010000000,
    S_RD_DATA  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic built, built_next;
  logic [CW-1:0] i, i_next, j, j_next, w, w_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic [VW-1:0] key, key_next, last, last_next;
  logic strict, strict_next;
  logic [CW-1:0] rank, rank_next;
  logic [31:0] entry, entry_next;
  logic [1:0] status, status_next;

  logic [VW-1:0] mem [TABLE_DEPTH];
  logic mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;

  logic accept, load, free;
  logic signed [63:0] v64;
  logic [VW-1:0] key_in;
  logic [63:0] e64;
  logic go_right;
  logic [CW-1:0] lo_s, hi_s, i_inc, w_inc;
  out_t res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign v64      = 64'(in_data.value);
  assign key_in   = v64[VW-1:0];
  assign e64      = 64'(rdata);
  assign go_right = strict ? ($signed(rdata) <= $signed(key))
                           : ($signed(rdata) < $signed(key));
  assign lo_s     = go_right ? mid + 1'b1 : lo;
  assign hi_s     = go_right ? hi : mid;
  assign i_inc    = i + 1'b1;
  assign w_inc    = w + 1'b1;

  always_comb begin
    state_next  = state;
    count_next  = count;
    built_next  = built;
    i_next      = i;
    j_next      = j;
    w_next      = w;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    key_next    = key;
    last_next   = last;
    strict_next = strict;
    rank_next   = rank;
    entry_next  = entry;
    status_next = status;
    mem_we      = 1'b0;
    waddr       = '0;
    wdata       = key;
    raddr       = '0;
    load        = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rank_next   = '0;
          entry_next  = '0;
          status_next = ST_OK;
          key_next    = key_in;
          strict_next = (in_data.opcode == OP_UPPER);
          state_next  = S_DONE;
          case (in_data.opcode)
            OP_ADD: begin
              if (32'(count) < 32'(TABLE_DEPTH)) begin
                mem_we     = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = key_in;
                count_next = count + 1'b1;
                built_next = 1'b0;
              end else begin
                status_next = ST_FULL;
              end
            end
            OP_BUILD: begin
              i_next = CW'(1);
              if (32'(count) >= 32'd2) begin
                raddr      = AW'(1);
                state_next = S_SORT_KEY;
              end else if (count != '0) begin
                state_next = S_DD_RD;
              end else begin
                built_next = 1'b1;
              end
            end
            OP_LOWER, OP_UPPER: begin
              if (!built) begin
                status_next = ST_NOT_BUILT;
              end else if (count != '0) begin
                lo_next    = '0;
                hi_next    = count;
                mid_next   = count >> 1;
                raddr      = mid_next[AW-1:0];
                state_next = S_SRCH;
              end
            end
            OP_READ: begin
              if (!built) begin
                status_next = ST_NOT_BUILT;
              end else if (32'(in_data.index) >= 32'(count)) begin
                status_next = ST_RANGE;
              end else begin
                raddr      = AW'(in_data.index);
                state_next = S_RD_DATA;
              end
            end
            default: ;
          endcase
        end
      end
      S_SORT_KEY: begin
        key_next   = rdata;
        j_next     = i;
        raddr      = AW'(i - 1'b1);
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP, S_SORT_INS: begin
        if (state == S_SORT_CMP && $signed(rdata) > $signed(key)) begin
          mem_we = 1'b1;
          waddr  = j[AW-1:0];
          wdata  = rdata;
          j_next = j - 1'b1;
          if (j_next == '0) begin
            state_next = S_SORT_INS;
          end else begin
            raddr = AW'(j_next - 1'b1);
          end
        end else begin
          mem_we = 1'b1;
          waddr  = j[AW-1:0];
          wdata  = key;
          i_next = i_inc;
          if (i_inc < count) begin
            raddr      = i_inc[AW-1:0];
            state_next = S_SORT_KEY;
          end else begin
            state_next = S_DD_RD;
          end
        end
      end
      S_DD_RD: begin
        raddr      = '0;
        state_next = S_DD_V0;
      end
      S_DD_V0: begin
        last_next = rdata;
        i_next    = CW'(1);
        w_next    = CW'(1);
        if (count == CW'(1)) begin
          built_next = 1'b1;
          state_next = S_DONE;
        end else begin
          raddr      = AW'(1);
          state_next = S_DD_CMP;
        end
      end
      S_DD_CMP: begin
        if (rdata != last) begin
          mem_we    = 1'b1;
          waddr     = w[AW-1:0];
          wdata     = rdata;
          last_next = rdata;
          w_next    = w_inc;
        end
        i_next = i_inc;
        if (i_inc == count) begin
          count_next = w_next;
          built_next = 1'b1;
          state_next = S_DONE;
        end else begin
          raddr = i_inc[AW-1:0];
        end
      end
      S_SRCH: begin
        lo_next = lo_s;
        hi_next = hi_s;
        if (lo_s < hi_s) begin
          mid_next = lo_s + ((hi_s - lo_s) >> 1);
          raddr    = mid_next[AW-1:0];
        end else begin
          rank_next  = lo_s;
          state_next = S_DONE;
        end
      end
      S_RD_DATA: begin
        entry_next = e64[31:0];
        state_next = S_DONE;
      end
      S_DONE: begin
        if (free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      built <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      built <= built_next;
    end
  end

  always_ff @(posedge clk) begin
    i      <= i_next;
    j      <= j_next;
    w      <= w_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    key    <= key_next;
    last   <= last_next;
    strict <= strict_next;
    rank   <= rank_next;
    entry  <= entry_next;
    status <= status_next;
  end

  assign res.rank        = 11'(rank);
  assign res.entry_value = $signed(entry);
  assign res.entry_count = 11'(count);
  assign res.status      = status;

  cct_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `CCT_ASSERT_IMP(a_count_max, clk, rst, 1'b1, 32'(count) <= 32'(TABLE_DEPTH))
  `CCT_ASSERT_IMP(a_srch_nowr, clk, rst, state == S_SRCH, !mem_we && lo < hi)
  `CCT_ASSERT_NXT(a_add_unbuilt, clk, rst,
    accept && in_data.opcode == OP_ADD && 32'(count) < 32'(TABLE_DEPTH), !built)
  `CCT_ASSERT_NXT(a_load_idle, clk, rst, load, state == S_IDLE && out_valid)

endmodule
